>>> src/irclt_pkg.sv
package irclt_pkg;

  // Default for the parameter count limit (capped at 15 by the 4-bit count)
  localparam int unsigned MaxParamsDefault = 15;

  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteColon = 8'h3A;

  localparam logic [3:0] CmdUnknown = 4'd0;

  typedef enum logic [2:0] {
    PhStart     = 3'd0,
    PhPrefix    = 3'd1,
    PhGap       = 3'd2,
    PhCmd       = 3'd3,
    PhParam     = 3'd4,
    PhTrailOpen = 3'd5,
    PhTrail     = 3'd6,
    PhOrphan    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindPrefix  = 2'd0,
    KindParam   = 2'd1,
    KindSummary = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    KwPass    = 3'd0,
    KwUser    = 3'd1,
    KwNick    = 3'd2,
    KwPrivmsg = 3'd3,
    KwJoin    = 3'd4,
    KwPart    = 3'd5,
    KwQuit    = 3'd6,
    KwList    = 3'd7
  } keyword_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [3:0] param_index;
    logic       token_start;
    logic       is_trailing;
    logic [3:0] command_code;
    logic [3:0] param_count;
    logic       count_overflow;
    logic       last;
  } out_item_t;

  // Results caused by one input beat: one or two
  typedef struct packed {
    out_item_t res0;
    out_item_t res1;
    logic      two;
  } slot_t;

  // Keyword text, left aligned, upper case
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [63:0] w;
    w = 64'h0;
    unique case (keyword_e'(k))
      KwPass:    w = {"PASS", 32'h0};
      KwUser:    w = {"USER", 32'h0};
      KwNick:    w = {"NICK", 32'h0};
      KwPrivmsg: w = {"PRIVMSG", 8'h0};
      KwJoin:    w = {"JOIN", 32'h0};
      KwPart:    w = {"PART", 32'h0};
      KwQuit:    w = {"QUIT", 32'h0};
      KwList:    w = {"LIST", 32'h0};
      default:   w = 64'h0;
    endcase
    kw_char = w[63 - 8 * int'(p) -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    kw_len = (keyword_e'(k) == KwPrivmsg) ? 4'd7 : 4'd4;
  endfunction

endpackage

>>> src/irclt_core.sv
module irclt_core
  import irclt_pkg::*;
#(
  parameter int unsigned MaxParams = MaxParamsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t in_beat_i,
  output logic     push_o,
  output slot_t    slot_o
);

  localparam int unsigned CountLimit = (MaxParams < 15) ? MaxParams : 15;
  localparam logic [3:0]  Limit      = 4'(CountLimit);

  phase_e     phase_q, phase_d;
  logic       prev_space_q, prev_space_d;
  logic [7:0] alive_q, alive_d;
  logic [3:0] cmd_len_q, cmd_len_d;
  logic       cmd_seen_q, cmd_seen_d;
  logic [3:0] params_q, params_d;
  logic       ovf_q, ovf_d;

  logic [7:0] b, up;
  logic       sp, colon;
  logic [7:0] alive_m;
  logic [3:0] len_m;
  logic       open_full;
  logic [3:0] open_params, open_idx, cur_idx;
  logic       byte_v;
  out_item_t  byte_res, sum_res;
  logic [3:0] code;

  assign b     = in_beat_i.data_byte;
  assign sp    = (b == ByteSpace);
  assign colon = (b == ByteColon);
  assign up    = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;

  // Narrow the keyword candidates with this command byte
  always_comb begin
    alive_m = alive_q;
    for (int k = 0; k < 8; k++) begin
      if (cmd_len_q >= kw_len(3'(k)) || kw_char(3'(k), cmd_len_q[2:0]) != up) begin
        alive_m[k] = 1'b0;
      end
    end
    len_m = (cmd_len_q < 4'd15) ? cmd_len_q + 4'd1 : cmd_len_q;
  end

  // Parameter opening and index of the parameter in progress
  assign open_full   = (params_q >= Limit);
  assign open_params = open_full ? params_q : params_q + 4'd1;
  assign open_idx    = open_full ? Limit : params_q;
  assign cur_idx     = (ovf_q || params_q == 4'd0) ? Limit : params_q - 4'd1;

  // Tokenizer state machine
  always_comb begin
    phase_d    = phase_q;
    alive_d    = alive_q;
    cmd_len_d  = cmd_len_q;
    cmd_seen_d = cmd_seen_q;
    params_d   = params_q;
    ovf_d      = ovf_q;
    byte_v     = 1'b0;
    byte_res   = '0;
    byte_res.out_byte = b;

    unique case (phase_q)
      PhStart: begin
        if (sp) begin
        end else if (colon) begin
          byte_v               = 1'b1;
          byte_res.kind        = KindPrefix;
          byte_res.token_start = 1'b1;
          phase_d              = PhPrefix;
        end else begin
          cmd_seen_d = 1'b1;
          alive_d    = alive_m;
          cmd_len_d  = len_m;
          phase_d    = PhCmd;
        end
      end
      PhPrefix: begin
        if (sp) begin
          phase_d = PhGap;
        end else begin
          byte_v        = 1'b1;
          byte_res.kind = KindPrefix;
        end
      end
      PhGap: begin
        if (sp) begin
        end else if (colon && prev_space_q) begin
          if (cmd_seen_q) begin
            params_d = open_params;
            ovf_d    = ovf_q | open_full;
            phase_d  = PhTrailOpen;
          end else begin
            phase_d = PhOrphan;
          end
        end else if (!cmd_seen_q) begin
          cmd_seen_d = 1'b1;
          alive_d    = alive_m;
          cmd_len_d  = len_m;
          phase_d    = PhCmd;
        end else begin
          params_d             = open_params;
          ovf_d                = ovf_q | open_full;
          byte_v               = 1'b1;
          byte_res.kind        = KindParam;
          byte_res.param_index = open_idx;
          byte_res.token_start = 1'b1;
          phase_d              = PhParam;
        end
      end
      PhCmd: begin
        if (sp) begin
          phase_d = PhGap;
        end else begin
          alive_d   = alive_m;
          cmd_len_d = len_m;
        end
      end
      PhParam: begin
        if (sp) begin
          phase_d = PhGap;
        end else begin
          byte_v               = 1'b1;
          byte_res.kind        = KindParam;
          byte_res.param_index = cur_idx;
        end
      end
      PhTrailOpen: begin
        byte_v               = 1'b1;
        byte_res.kind        = KindParam;
        byte_res.param_index = cur_idx;
        byte_res.token_start = 1'b1;
        byte_res.is_trailing = 1'b1;
        phase_d              = PhTrail;
      end
      PhTrail: begin
        byte_v               = 1'b1;
        byte_res.kind        = KindParam;
        byte_res.param_index = cur_idx;
        byte_res.is_trailing = 1'b1;
      end
      PhOrphan: begin
      end
      default: begin
      end
    endcase

    prev_space_d  = sp;
    byte_res.last = ~in_beat_i.end_of_line;
  end

  // Resolve the command code, lowest keyword wins
  always_comb begin
    code = CmdUnknown;
    for (int k = 7; k >= 0; k--) begin
      if (cmd_seen_d && alive_d[k] && kw_len(3'(k)) == cmd_len_d) begin
        code = 4'(k) + 4'd1;
      end
    end
  end

  // Line summary
  always_comb begin
    sum_res                = '0;
    sum_res.kind           = KindSummary;
    sum_res.command_code   = code;
    sum_res.param_count    = params_d;
    sum_res.count_overflow = ovf_d;
    sum_res.last           = 1'b1;
  end

  assign slot_o.res0 = byte_v ? byte_res : sum_res;
  assign slot_o.res1 = sum_res;
  assign slot_o.two  = byte_v & in_beat_i.end_of_line;
  assign push_o      = accept_i & (byte_v | in_beat_i.end_of_line);

  // Advance line state per accepted beat; drop back to start at line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart;
      prev_space_q <= 1'b0;
      alive_q      <= '1;
      cmd_len_q    <= '0;
      cmd_seen_q   <= 1'b0;
      params_q     <= '0;
      ovf_q        <= 1'b0;
    end else if (accept_i) begin
      if (in_beat_i.end_of_line) begin
        phase_q      <= PhStart;
        prev_space_q <= 1'b0;
        alive_q      <= '1;
        cmd_len_q    <= '0;
        cmd_seen_q   <= 1'b0;
        params_q     <= '0;
        ovf_q        <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        prev_space_q <= prev_space_d;
        alive_q      <= alive_d;
        cmd_len_q    <= cmd_len_d;
        cmd_seen_q   <= cmd_seen_d;
        params_q     <= params_d;
        ovf_q        <= ovf_d;
      end
    end
  end

endmodule

>>> src/irclt_out_buf.sv
module irclt_out_buf
  import irclt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  slot_t     slot_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  slot_t      slots_q [2];
  logic       wptr_q, rptr_q, sub_q;
  logic [1:0] count_q;
  slot_t      cur;
  logic       pop_beat, slot_done;

  assign cur         = slots_q[rptr_q];
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = sub_q ? cur.res1 : cur.res0;
  assign full_o      = (count_q == 2'd2);
  assign pop_beat    = out_valid_o & ~out_stall_i;
  assign slot_done   = pop_beat & (sub_q | ~cur.two);

  // Hold result slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= slot_i;
    end
  end

  // Advance pointers and the per-slot beat select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      sub_q   <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (slot_done) begin
        rptr_q <= ~rptr_q;
      end
      if (pop_beat) begin
        sub_q <= ~slot_done;
      end
      case ({push_i, slot_done})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> src/irc_line_tokenizer.sv
// Streaming tokenizer for chat-protocol command lines.
// Input channel: one line byte per beat (in_valid_i/in_stall_o), with
// end_of_line set on the last byte. Output channel (out_valid_o/out_stall_i)
// carries prefix bytes, parameter bytes and one summary beat per line with
// the command code and the saturating parameter count.
// A byte's results are written to the result buffer when it is accepted.
// Throughput: one input byte per cycle while the buffer is not full. A byte
// causes at most one result, except the end-of-line byte, which can cause a
// byte result and the summary; those two leave the two-slot result buffer
// one after the other, so a line end can stall the input side.
// Reset puts the tokenizer at the start of a line and empties the buffer.
// When the receiver stalls, the buffer fills; once both slots hold results
// in_stall_o rises and stays high until a slot drains. The output beat
// holds steady while stalled.
module irc_line_tokenizer
  import irclt_pkg::*;
#(
  parameter int unsigned MaxParams = MaxParamsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic  accept;
  logic  push;
  logic  full;
  slot_t slot;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  irclt_core #(
    .MaxParams(MaxParams)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_beat_i(in_data_i),
    .push_o   (push),
    .slot_o   (slot)
  );

  irclt_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .slot_i     (slot),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
